[rtl/hwst_pkg.sv]
`default_nettype none

package hwst_pkg;

  localparam int HEIGHT_BITS = 16;
  localparam int COORD_W     = 8;
  localparam int DIM_W       = 9;
  localparam int IDX_W       = 17;
  localparam int DEPTH_W     = 16;
  localparam int SIDES_W     = 4;
  localparam int CNT_W       = 18;
  localparam int SUM_W       = HEIGHT_BITS + 3;
  localparam int ABS_W       = HEIGHT_BITS + 1;

  localparam logic [DIM_W-1:0] MAX_GRID_WIDTH = DIM_W'(256);
  localparam logic [DIM_W-1:0] MAX_GRID_DEPTH = DIM_W'(256);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register map
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_SURF_LEVEL = 2'd0;
  localparam logic [1:0] REG_GRID_WIDTH = 2'd1;
  localparam logic [1:0] REG_GRID_DEPTH = 2'd2;

  // boundary mask bit positions
  localparam int SIDE_Z_FIRST = 0;
  localparam int SIDE_Z_LAST  = 1;
  localparam int SIDE_X_FIRST = 2;
  localparam int SIDE_X_LAST  = 3;

  typedef struct packed {
    logic        [COORD_W-1:0]     cell_x;
    logic        [COORD_W-1:0]     cell_z;
    logic signed [HEIGHT_BITS-1:0] corner_h00;
    logic signed [HEIGHT_BITS-1:0] corner_h10;
    logic signed [HEIGHT_BITS-1:0] corner_h01;
    logic signed [HEIGHT_BITS-1:0] corner_h11;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   vertex_a;
    logic [IDX_W-1:0]   vertex_b;
    logic [IDX_W-1:0]   vertex_c;
    logic               split_other;
    logic [DEPTH_W-1:0] cell_water_depth;
    logic [SIDES_W-1:0] edge_sides;
    logic [IDX_W-1:0]   triangle_number;
    logic               last_of_cell;
  } out_item_t;

  // one submerged cell handed from front to back
  typedef struct packed {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_z;
    logic               split_other;
    logic [DEPTH_W-1:0] depth;
    logic [SIDES_W-1:0] sides;
  } cell_cmd_t;

  typedef struct packed {
    logic      push;
    cell_cmd_t cmd;
  } queue_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] m);
    return (v > m) ? m : v;
  endfunction

endpackage

`default_nettype wire

[rtl/hwst_front.sv]
`default_nettype none

module hwst_front (
  input  wire                                  in_valid,
  input  hwst_pkg::in_item_t                   in_data,
  output logic                                 in_stall,
  input  wire signed [hwst_pkg::HEIGHT_BITS-1:0] surf_level,
  input  wire        [hwst_pkg::DIM_W-1:0]     grid_w,
  input  wire        [hwst_pkg::DIM_W-1:0]     grid_d,
  input  hwst_pkg::queue_stat_t                q_stat,
  output hwst_pkg::queue_wr_t                  q_wr
);
  import hwst_pkg::*;

  logic                    in_grid;
  logic                    submerged;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] diff;
  logic signed [ABS_W-1:0] d_a;
  logic signed [ABS_W-1:0] d_b;
  logic        [ABS_W-1:0] abs_a;
  logic        [ABS_W-1:0] abs_b;
  logic [DEPTH_W-1:0]      depth;
  logic [SIDES_W-1:0]      sides;

  assign in_stall = q_stat.full;

  always_comb begin
    in_grid = ({1'b0, in_data.cell_x} < grid_w) && ({1'b0, in_data.cell_z} < grid_d);
    submerged = (in_data.corner_h00 < surf_level) || (in_data.corner_h10 < surf_level) ||
                (in_data.corner_h01 < surf_level) || (in_data.corner_h11 < surf_level);

    // 4*level - sum of corners, then floor divide by four; zero if not positive
    sum = SUM_W'(in_data.corner_h00) + SUM_W'(in_data.corner_h10) +
          SUM_W'(in_data.corner_h01) + SUM_W'(in_data.corner_h11);
    diff = (SUM_W'(surf_level) <<< 2) - sum;
    if (diff[SUM_W-1] || (diff == '0)) begin
      depth = '0;
    end else begin
      depth = diff[DEPTH_W+1:2];
    end

    d_a = ABS_W'(in_data.corner_h00) - ABS_W'(in_data.corner_h11);
    d_b = ABS_W'(in_data.corner_h10) - ABS_W'(in_data.corner_h01);
    abs_a = d_a[ABS_W-1] ? ABS_W'(-d_a) : ABS_W'(d_a);
    abs_b = d_b[ABS_W-1] ? ABS_W'(-d_b) : ABS_W'(d_b);

    sides = '0;
    sides[SIDE_Z_FIRST] = (in_data.cell_z == '0);
    sides[SIDE_Z_LAST]  = ({1'b0, in_data.cell_z} == (grid_d - DIM_W'(1)));
    sides[SIDE_X_FIRST] = (in_data.cell_x == '0);
    sides[SIDE_X_LAST]  = ({1'b0, in_data.cell_x} == (grid_w - DIM_W'(1)));

    q_wr.push            = in_valid && !q_stat.full && in_grid && submerged;
    q_wr.cmd.cell_x      = in_data.cell_x;
    q_wr.cmd.cell_z      = in_data.cell_z;
    q_wr.cmd.split_other = (abs_a > abs_b);
    q_wr.cmd.depth       = depth;
    q_wr.cmd.sides       = sides;
  end

endmodule

`default_nettype wire

[rtl/hwst_queue.sv]
`default_nettype none

module hwst_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  hwst_pkg::queue_wr_t    q_wr,
  input  wire                    pop,
  output hwst_pkg::cell_cmd_t    rd_data,
  output hwst_pkg::queue_stat_t  q_stat
);
  import hwst_pkg::*;

  cell_cmd_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_nxt;

  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign rd_data      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_wr.push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (q_wr.push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !q_wr.push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.cmd;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue holds more entries than its depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

[rtl/hwst_back.sv]
`default_nettype none

module hwst_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire [hwst_pkg::DIM_W-1:0]   grid_w,
  input  hwst_pkg::queue_stat_t       q_stat,
  input  hwst_pkg::cell_cmd_t         head,
  output logic                        pop,
  output logic                        out_valid,
  input  wire                         out_stall,
  output hwst_pkg::out_item_t         out_data
);
  import hwst_pkg::*;

  logic               cur_valid_r;
  logic               phase_r;
  logic [IDX_W-1:0]   i00_r;
  logic               split_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [SIDES_W-1:0] sides_r;
  logic [CNT_W-1:0]   count_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic [DIM_W-1:0]   stride;
  logic [IDX_W-1:0]   i00_nxt;
  logic [IDX_W-1:0]   i10;
  logic [IDX_W-1:0]   i01;
  logic [IDX_W-1:0]   i11;
  logic               out_load;
  logic               done;
  out_item_t          out_nxt;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    stride   = grid_w + DIM_W'(1);
    i00_nxt  = IDX_W'(head.cell_z) * IDX_W'(stride) + IDX_W'(head.cell_x);
    i10      = i00_r + IDX_W'(1);
    i01      = i00_r + IDX_W'(stride);
    i11      = i01 + IDX_W'(1);
    out_load = cur_valid_r && (!out_valid_r || !out_stall);
    done     = out_load && phase_r;
    pop      = !q_stat.empty && (!cur_valid_r || done);

    out_nxt.split_other      = split_r;
    out_nxt.cell_water_depth = depth_r;
    out_nxt.edge_sides       = sides_r;
    out_nxt.triangle_number  = count_r[IDX_W-1:0];
    out_nxt.last_of_cell     = phase_r;
    unique case ({split_r, phase_r})
      2'b00: begin
        out_nxt.vertex_a = i00_r;
        out_nxt.vertex_b = i11;
        out_nxt.vertex_c = i10;
      end
      2'b01: begin
        out_nxt.vertex_a = i00_r;
        out_nxt.vertex_b = i01;
        out_nxt.vertex_c = i11;
      end
      2'b10: begin
        out_nxt.vertex_a = i00_r;
        out_nxt.vertex_b = i01;
        out_nxt.vertex_c = i10;
      end
      default: begin
        out_nxt.vertex_a = i10;
        out_nxt.vertex_b = i01;
        out_nxt.vertex_c = i11;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid_r <= 1'b1;
        phase_r     <= 1'b0;
      end else if (done) begin
        cur_valid_r <= 1'b0;
        phase_r     <= 1'b0;
      end else if (out_load) begin
        phase_r <= 1'b1;
      end
      if (out_load) begin
        count_r     <= count_r + CNT_W'(1);
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      i00_r   <= i00_nxt;
      split_r <= head.split_other;
      depth_r <= head.depth;
      sides_r <= head.sides;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !phase_r) |=> (cur_valid_r && phase_r))
    else $error("first triangle of a cell not followed by its second");
  a_pop_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cur_valid_r) |-> (out_load && phase_r))
    else $error("new cell taken while current cell unfinished");
`endif

endmodule

`default_nettype wire

[rtl/heightmap_water_surface_triangulator_core.sv]
`default_nettype none

// water surface triangulator: takes one terrain cell per beat (column, row, four
// signed q8.8 corner heights) and, for a cell inside the configured grid with a
// corner strictly below the surface level, emits two triangle beats of vertex indices
// z*(width+1)+x split along the flatter diagonal; dry or out-of-grid cells are
// taken and dropped. the front classifies one cell per cycle into a two-entry queue,
// stalling the input while it is full, and the back's single triangle emitter
// drains it at two triangles per submerged cell, which sets the sustained rate;
// dry cells never enter the queue. registers sit at byte addresses 0 (surface level),
// 4 (grid_width), 8 (grid_depth); grid sizes above 256 act as 256, and writes should
// be made only while idle.
module heightmap_water_surface_triangulator_core (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  hwst_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output hwst_pkg::out_item_t                  out_data,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [hwst_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire [hwst_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [hwst_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import hwst_pkg::*;

  logic signed [HEIGHT_BITS-1:0] surf_level_r;
  logic [DIM_W-1:0]              grid_width_r;
  logic [DIM_W-1:0]              grid_depth_r;
  logic [DIM_W-1:0]              grid_w;
  logic [DIM_W-1:0]              grid_d;
  logic                          cfg_wr;
  logic [1:0]                    reg_sel;

  queue_wr_t   q_wr;
  queue_stat_t q_stat;
  cell_cmd_t   head;
  logic        pop;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign grid_w  = sat_dim(grid_width_r, MAX_GRID_WIDTH);
  assign grid_d  = sat_dim(grid_depth_r, MAX_GRID_DEPTH);

  always_comb begin
    unique case (reg_sel)
      REG_SURF_LEVEL: prdata = APB_DATA_W'(surf_level_r);
      REG_GRID_WIDTH: prdata = APB_DATA_W'(grid_width_r);
      REG_GRID_DEPTH: prdata = APB_DATA_W'(grid_depth_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surf_level_r <= '0;
      grid_width_r <= DIM_W'(1);
      grid_depth_r <= DIM_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_SURF_LEVEL: surf_level_r <= pwdata[HEIGHT_BITS-1:0];
        REG_GRID_WIDTH: grid_width_r <= pwdata[DIM_W-1:0];
        REG_GRID_DEPTH: grid_depth_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  hwst_front u_front (
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .surf_level  (surf_level_r),
    .grid_w      (grid_w),
    .grid_d      (grid_d),
    .q_stat      (q_stat),
    .q_wr        (q_wr)
  );

  hwst_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .pop     (pop),
    .rd_data (head),
    .q_stat  (q_stat)
  );

  hwst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .grid_w    (grid_w),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_grid_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (grid_w <= MAX_GRID_WIDTH) && (grid_d <= MAX_GRID_DEPTH))
    else $error("effective grid size above its maximum");
`endif

endmodule

`default_nettype wire

[dv/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hwst_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  heightmap_water_surface_triangulator_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // register mirrors and triangle counter of the predictor
  logic signed [HEIGHT_BITS-1:0] lvl_cfg = '0;
  logic [DIM_W-1:0] width_cfg = DIM_W'(1);
  logic [DIM_W-1:0] depth_cfg = DIM_W'(1);
  logic [CNT_W-1:0] tri_count = '0;

  in_item_t cell_q[$];
  out_item_t tri_expect_q[$];

  int mismatches = 0;
  int cells_taken = 0;
  int tris_checked = 0;
  int settings_used = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int sink_hold = 0;
  bit hold_req = 1'b0;
  bit idle_on = 1'b1;
  out_item_t tri_want;

  function automatic int eff_width();
    return (width_cfg > MAX_GRID_WIDTH) ? int'(MAX_GRID_WIDTH) : int'(width_cfg);
  endfunction

  function automatic int eff_depth();
    return (depth_cfg > MAX_GRID_DEPTH) ? int'(MAX_GRID_DEPTH) : int'(depth_cfg);
  endfunction

  function automatic void predict_triangles(input in_item_t c);
    int w, d, x, z, lvl, h00, h10, h01, h11, diff, dep, ad0, ad1;
    int unsigned stride, i00, i10, i01, i11;
    logic [SIDES_W-1:0] sides;
    logic alt;
    out_item_t t;
    w = eff_width();
    d = eff_depth();
    x = int'(c.cell_x);
    z = int'(c.cell_z);
    lvl = int'($signed(lvl_cfg));
    h00 = int'($signed(c.corner_h00));
    h10 = int'($signed(c.corner_h10));
    h01 = int'($signed(c.corner_h01));
    h11 = int'($signed(c.corner_h11));
    if (x >= w || z >= d) return;
    if (!(h00 < lvl || h10 < lvl || h01 < lvl || h11 < lvl)) return;
    stride = w + 1;
    i00 = z * stride + x;
    i10 = i00 + 1;
    i01 = i00 + stride;
    i11 = i01 + 1;
    diff = 4 * lvl - (h00 + h10 + h01 + h11);
    dep = (diff <= 0) ? 0 : (diff >>> 2);
    if (dep > 65535) dep = 65535;
    sides = '0;
    if (z == 0) sides[SIDE_Z_FIRST] = 1'b1;
    if (z == d - 1) sides[SIDE_Z_LAST] = 1'b1;
    if (x == 0) sides[SIDE_X_FIRST] = 1'b1;
    if (x == w - 1) sides[SIDE_X_LAST] = 1'b1;
    ad0 = (h00 > h11) ? h00 - h11 : h11 - h00;
    ad1 = (h10 > h01) ? h10 - h01 : h01 - h10;
    // ties keep the h00-h11 diagonal
    alt = !(ad0 <= ad1);
    t.split_other = alt;
    t.cell_water_depth = dep[DEPTH_W-1:0];
    t.edge_sides = sides;
    t.vertex_a = i00[IDX_W-1:0];
    t.vertex_b = alt ? i01[IDX_W-1:0] : i11[IDX_W-1:0];
    t.vertex_c = i10[IDX_W-1:0];
    t.triangle_number = tri_count[IDX_W-1:0];
    t.last_of_cell = 1'b0;
    tri_expect_q.push_back(t);
    tri_count = tri_count + 1'b1;
    t.vertex_a = alt ? i10[IDX_W-1:0] : i00[IDX_W-1:0];
    t.vertex_b = i01[IDX_W-1:0];
    t.vertex_c = i11[IDX_W-1:0];
    t.triangle_number = tri_count[IDX_W-1:0];
    t.last_of_cell = 1'b1;
    tri_expect_q.push_back(t);
    tri_count = tri_count + 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // driver: one cell beat at a time from cell_q
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_triangles(in_data);
        cells_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (cell_q.size() != 0) begin
          in_data <= cell_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each triangle beat and drives the receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tri_expect_q.size() == 0) begin
          $error("triangle beat with nothing expected: %p", out_data);
          mismatches++;
        end else begin
          tri_want = tri_expect_q.pop_front();
          check_field("vertex_a", tri_want.vertex_a, out_data.vertex_a);
          check_field("vertex_b", tri_want.vertex_b, out_data.vertex_b);
          check_field("vertex_c", tri_want.vertex_c, out_data.vertex_c);
          check_field("split_other", tri_want.split_other, out_data.split_other);
          check_field("cell_water_depth", tri_want.cell_water_depth,
                      out_data.cell_water_depth);
          check_field("edge_sides", tri_want.edge_sides, out_data.edge_sides);
          check_field("triangle_number", tri_want.triangle_number,
                      out_data.triangle_number);
          check_field("last_of_cell", tri_want.last_of_cell, out_data.last_of_cell);
          tris_checked++;
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        sink_hold = 90;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_stall <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SURF_LEVEL: lvl_cfg = val[HEIGHT_BITS-1:0];
      REG_GRID_WIDTH: width_cfg = val[DIM_W-1:0];
      REG_GRID_DEPTH: depth_cfg = val[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input int lvl, input int w, input int d);
    write_reg(REG_SURF_LEVEL, lvl);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_DEPTH, d);
    settings_used++;
  endtask

  // look between edges so the driver's updates have settled;
  // dry cells leave no result, so keep clocking after the queues are empty
  task automatic wait_drained();
    while (cell_q.size() != 0 || in_valid || tri_expect_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_cell(input int x, input int z, input int h00, input int h10,
                           input int h01, input int h11);
    in_item_t c;
    c.cell_x = x[COORD_W-1:0];
    c.cell_z = z[COORD_W-1:0];
    c.corner_h00 = h00[HEIGHT_BITS-1:0];
    c.corner_h10 = h10[HEIGHT_BITS-1:0];
    c.corner_h01 = h01[HEIGHT_BITS-1:0];
    c.corner_h11 = h11[HEIGHT_BITS-1:0];
    cell_q.push_back(c);
  endtask

  // mostly near the water line so both wet and dry cells show up
  function automatic logic [HEIGHT_BITS-1:0] rand_height();
    int r, v;
    r = $urandom_range(0, 9);
    if (r == 0) v = int'($urandom_range(0, 65535)) - 32768;
    else if (r == 1) v = $urandom_range(0, 1) ? 32767 : -32768;
    else v = $signed(lvl_cfg) + int'($urandom_range(0, 1536)) - 1024;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[HEIGHT_BITS-1:0];
  endfunction

  function automatic in_item_t rand_cell();
    in_item_t c;
    int w, d;
    w = eff_width();
    d = eff_depth();
    if (w > 0 && d > 0 && $urandom_range(0, 9) != 0) begin
      c.cell_x = COORD_W'($urandom_range(0, w - 1));
      c.cell_z = COORD_W'($urandom_range(0, d - 1));
    end else begin
      c.cell_x = COORD_W'($urandom_range(0, 255));
      c.cell_z = COORD_W'($urandom_range(0, 255));
    end
    c.corner_h00 = rand_height();
    c.corner_h10 = rand_height();
    c.corner_h01 = rand_height();
    c.corner_h11 = rand_height();
    return c;
  endfunction

  initial begin
    int ph, k, n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: one-cell grid at level zero
    push_cell(0, 0, -1, 5, 5, 5);
    push_cell(1, 0, -1, -1, -1, -1);
    wait_drained();

    set_grid(0, 256, 256);
    push_cell(0, 0, -32768, -32768, -32768, -32768);
    push_cell(255, 255, 32767, 32767, 32767, 32767);
    push_cell(255, 0, -1, 0, 0, 0);
    push_cell(0, 255, -3, -1, -1, -1);
    push_cell(10, 20, 0, 0, 0, 0);
    push_cell(3, 3, -100, 0, 100, 0);
    push_cell(4, 3, -1000, 0, 0, 1000);
    push_cell(5, 3, -1, 30000, 30000, 30000);
    push_cell(170, 85, -21846, 21845, -21846, 21845);
    wait_drained();

    set_grid(32767, 256, 256);
    push_cell(7, 7, -32768, -32768, -32768, -32768);
    push_cell(8, 8, 32767, 32767, 32767, 32767);
    push_cell(9, 9, 32766, 32767, 32767, 32767);
    wait_drained();

    set_grid(-32768, 256, 256);
    push_cell(0, 0, -32768, -32768, -32768, -32768);
    wait_drained();

    // zero width puts every cell outside the grid
    set_grid(0, 0, 256);
    push_cell(0, 0, -5, -5, -5, -5);
    wait_drained();

    // oversized grid acts as 256 by 256
    set_grid(0, 511, 300);
    push_cell(255, 255, -5, -5, -5, -5);
    push_cell(0, 0, -5, 7, 9, -5);
    wait_drained();

    set_grid(0, 4, 3);
    push_cell(4, 0, -5, -5, -5, -5);
    push_cell(0, 3, -5, -5, -5, -5);
    push_cell(3, 2, -5, -6, -7, -8);

    for (ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: set_grid(int'($urandom_range(0, 4000)) - 2000, 256, 256);
        1: set_grid(int'($urandom_range(0, 4000)) - 2000, $urandom_range(1, 8),
                    $urandom_range(1, 8));
        2: set_grid(32767, 256, 1);
        3: set_grid(-32768, 1, 256);
        4: set_grid(int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 511),
                    $urandom_range(0, 511));
        5: set_grid(int'($urandom_range(0, 4000)) - 2000, 300, 17);
        6: set_grid(int'($urandom_range(0, 4000)) - 2000, $urandom_range(1, 256),
                    $urandom_range(1, 256));
        default: set_grid(int'($urandom_range(0, 4000)) - 2000, 256, 256);
      endcase
      idle_on = (ph != 7);
      n = (ph == 3) ? 40 : 85;
      for (k = 0; k < n; k++) begin
        // receiver holds off while cells keep coming, so the block backs up
        if (ph == 1 && k == 10) hold_req = 1'b1;
        // sender pauses until every triangle so far has come out
        if (ph == 2 && k == 40) wait_drained();
        cell_q.push_back(rand_cell());
      end
    end
    wait_drained();
    repeat (10) @(posedge clk);

    $display("%0d cells taken over %0d grid settings, %0d triangles compared",
             cells_taken, settings_used, tris_checked);
    if (mismatches == 0) begin
      $display("** heightmap_water_surface_triangulator_core: PASSED **");
    end else begin
      $display("** heightmap_water_surface_triangulator_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for triangle beats");
    $display("** heightmap_water_surface_triangulator_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
